// File: hw/rtl/rrt_tree_nearest_steer_defines.svh
// Assertion macros shared by the tree search block.
// Depends on nothing; included by the files that carry assertions.
`ifndef RRT_TREE_NEAREST_STEER_DEFINES_SVH
`define RRT_TREE_NEAREST_STEER_DEFINES_SVH
`define RRT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rrt_tree_nearest_steer: invariant violated");
`define RRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrt_tree_nearest_steer: implication violated");
`endif

// File: hw/rtl/rrt_nst_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the tree search and steering block.
// Depends on nothing; used by the channel interfaces and the top level.
package rrt_nst_pkg;
   localparam int unsigned MaxNodes   = 1024;
   localparam int unsigned Dimensions = 6;
   localparam int unsigned DimIdxW    = 3;
   localparam int unsigned IdxW       = 10;
   localparam int unsigned ParW       = 11;
   localparam int unsigned CountW     = 11;
   localparam int unsigned CoordW     = 16;
   localparam int unsigned CfgW       = 16;
   localparam int unsigned CsrIdxW    = 4;
   localparam int unsigned RowW       = ParW + Dimensions * CoordW;
   localparam int unsigned SqW        = 33;
   localparam int unsigned D2W        = 36;
   localparam int unsigned RootW      = D2W / 2;
   localparam int unsigned RemW       = RootW + 3;
   localparam int unsigned ProdW      = 34;
   localparam int unsigned MagW       = ProdW - 1;

   localparam logic [ParW-1:0]    ROOT_PARENT   = ParW'(MaxNodes);
   localparam logic [CsrIdxW-1:0] CSR_MAX_STEP  = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_TOLERANCE = 4'd1;
   localparam logic [CfgW-1:0]    MAX_STEP_RST  = 16'd4096;
   localparam logic [CfgW-1:0]    TOLERANCE_RST = 16'd1;

   typedef enum logic [1:0] {
      CMD_CLEAR_ROOT = 2'd0,
      CMD_ADD_ROOT   = 2'd1,
      CMD_GROW       = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_ADVANCED = 3'd1,
      ST_REACHED  = 3'd2,
      ST_FULL     = 3'd3,
      ST_RANGE    = 3'd4
   } status_type;
endpackage

// File: hw/rtl/rrt_nst_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command words, result words and register writes.
// Depends on rrt_nst_pkg for field widths.
interface rrt_nst_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           command;
   logic signed [rrt_nst_pkg::CoordW-1:0] coord_0;
   logic signed [rrt_nst_pkg::CoordW-1:0] coord_1;
   logic signed [rrt_nst_pkg::CoordW-1:0] coord_2;
   logic signed [rrt_nst_pkg::CoordW-1:0] coord_3;
   logic signed [rrt_nst_pkg::CoordW-1:0] coord_4;
   logic signed [rrt_nst_pkg::CoordW-1:0] coord_5;
   logic [rrt_nst_pkg::IdxW-1:0]          read_index;
   modport source (output valid, command, coord_0, coord_1, coord_2, coord_3, coord_4,
                   coord_5, read_index, input ready);
   modport sink (input valid, command, coord_0, coord_1, coord_2, coord_3, coord_4,
                 coord_5, read_index, output ready);
endinterface

interface rrt_nst_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [2:0]                           status;
   logic [rrt_nst_pkg::IdxW-1:0]          node_index;
   logic [rrt_nst_pkg::ParW-1:0]          parent_index;
   logic signed [rrt_nst_pkg::CoordW-1:0] out_coord_0;
   logic signed [rrt_nst_pkg::CoordW-1:0] out_coord_1;
   logic signed [rrt_nst_pkg::CoordW-1:0] out_coord_2;
   logic signed [rrt_nst_pkg::CoordW-1:0] out_coord_3;
   logic signed [rrt_nst_pkg::CoordW-1:0] out_coord_4;
   logic signed [rrt_nst_pkg::CoordW-1:0] out_coord_5;
   modport source (output valid, status, node_index, parent_index, out_coord_0, out_coord_1,
                   out_coord_2, out_coord_3, out_coord_4, out_coord_5, input ready);
   modport sink (input valid, status, node_index, parent_index, out_coord_0, out_coord_1,
                 out_coord_2, out_coord_3, out_coord_4, out_coord_5, output ready);
endinterface

interface rrt_nst_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rrt_nst_pkg::CsrIdxW-1:0] index;
   logic [rrt_nst_pkg::CfgW-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rrt_tree_nearest_steer.sv
`timescale 1ns / 1ps
// Tree store with nearest-node search and fixed-point steering toward a target.
// Depends on rrt_nst_pkg, the channel interfaces and the assertion macro header.
//
// Use: one command word enters on req_ch when ready is high, and exactly one
// result word leaves on rsp_ch. Commands are clear-and-add-root, add root,
// grow toward a target and read node. Register writes on csr_ch (max_step,
// tolerance) are always taken and must only come while the block is idle.
// Clear, add root and read fetch the node row before showing their result, and
// rejected words go straight to the result. Grow sweeps the node memory one node
// per cycle, then ends when the nearest node is reached or the table is full,
// writes the target itself when it lies within max_step, and else steers from
// the nearest node by a square root and six joint steps, each with a divide.
// The block is ready for the next word in the same cycle as the result appears,
// and the result waits in an output register meanwhile. A stalled receiver
// holds the result and, once a second result is ready, the block waits before
// accepting more. Reset empties the tree and loads the register defaults; node
// memory contents are not cleared.
`include "rrt_tree_nearest_steer_defines.svh"
module rrt_tree_nearest_steer (
   input logic            clock,
   input logic            reset,
   rrt_nst_req_if.sink    req_ch,
   rrt_nst_rsp_if.source  rsp_ch,
   rrt_nst_csr_if.sink    csr_ch
);
   localparam int unsigned Dim     = rrt_nst_pkg::Dimensions;
   localparam int unsigned MaxN    = rrt_nst_pkg::MaxNodes;
   localparam int unsigned IdxW    = rrt_nst_pkg::IdxW;
   localparam int unsigned ParW    = rrt_nst_pkg::ParW;
   localparam int unsigned CountW  = rrt_nst_pkg::CountW;
   localparam int unsigned CoordW  = rrt_nst_pkg::CoordW;
   localparam int unsigned CfgW    = rrt_nst_pkg::CfgW;
   localparam int unsigned RowW    = rrt_nst_pkg::RowW;
   localparam int unsigned SqW     = rrt_nst_pkg::SqW;
   localparam int unsigned D2W     = rrt_nst_pkg::D2W;
   localparam int unsigned RootW   = rrt_nst_pkg::RootW;
   localparam int unsigned RemW    = rrt_nst_pkg::RemW;
   localparam int unsigned ProdW   = rrt_nst_pkg::ProdW;
   localparam int unsigned MagW    = rrt_nst_pkg::MagW;
   localparam int unsigned DimIdxW = rrt_nst_pkg::DimIdxW;
   localparam int unsigned SqCntW  = $clog2(RootW);
   localparam int unsigned DivCntW = $clog2(MagW);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_SCAN   = 12'b000000000010,
      S_DECIDE = 12'b000000000100,
      S_FROM   = 12'b000000001000,
      S_SQRT   = 12'b000000010000,
      S_MUL    = 12'b000000100000,
      S_DIV    = 12'b000001000000,
      S_ACC    = 12'b000010000000,
      S_WRITE  = 12'b000100000000,
      S_CHECK  = 12'b001000000000,
      S_READ   = 12'b010000000000,
      S_EMIT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CfgW-1:0] max_step_ff, tolerance_ff;
   logic [2*CfgW-1:0] ms2_ff, tol2_ff;
   logic [CountW-1:0] count_ff;
   logic signed [CoordW-1:0] tgt_in [Dim];
   logic signed [CoordW-1:0] tgt_ff [Dim];
   logic signed [CoordW-1:0] from_ff [Dim];
   logic signed [CoordW-1:0] new_ff [Dim];
   rrt_nst_pkg::status_type status_ff;
   logic [IdxW-1:0] rd_idx_ff;

   logic [RowW-1:0] node_mem [MaxN];
   logic [RowW-1:0] rd_q_ff;
   logic            mem_we, mem_re;
   logic [IdxW-1:0] mem_wa, mem_ra;
   logic [RowW-1:0] mem_wd;

   logic [IdxW-1:0] scan_addr_ff, scan_last_ff;
   logic            issuing_ff;
   logic            v1_ff, v2_ff, v3_ff;
   logic [IdxW-1:0] i1_ff, i2_ff, i3_ff;
   logic [SqW-1:0]  sq_ff [Dim];
   logic [SqW-1:0]  sq_in [Dim];
   logic [D2W-1:0]  sum_ff, sum_in;
   logic [D2W-1:0]  best_ff;
   logic [IdxW-1:0] nearest_ff;
   logic            has_best_ff;

   logic [D2W-1:0]    rad_ff;
   logic [RootW-1:0]  root_ff;
   logic [RemW-1:0]   srem_ff, srem_next, strial;
   logic [SqCntW-1:0] sq_cnt_ff;

   logic [DimIdxW-1:0]        dim_ff;
   logic signed [CoordW:0]    step_diff;
   logic signed [ProdW-1:0]   prod;
   logic                      neg_ff;
   logic [MagW-1:0]           dvd_ff;
   logic [RootW:0]            drem_ff, drem_shift;
   logic [DivCntW-1:0]        div_cnt_ff;
   logic signed [CoordW+1:0]  q_signed;

   logic [rrt_nst_pkg::CsrIdxW-1:0] csr_idx;
   rrt_nst_pkg::cmd_type req_cmd;
   logic req_acc, rsp_free, scan_idle, table_full;

   logic                    rsp_valid_ff;
   rrt_nst_pkg::status_type rsp_status_ff;
   logic [IdxW-1:0]         rsp_node_ff;
   logic [ParW-1:0]         rsp_parent_ff;
   logic signed [CoordW-1:0] rsp_coord_ff [Dim];
   logic                    rsp_err;

   assign tgt_in[0] = req_ch.coord_0;
   assign tgt_in[1] = req_ch.coord_1;
   assign tgt_in[2] = req_ch.coord_2;
   assign tgt_in[3] = req_ch.coord_3;
   assign tgt_in[4] = req_ch.coord_4;
   assign tgt_in[5] = req_ch.coord_5;

   assign req_cmd    = rrt_nst_pkg::cmd_type'(req_ch.command);
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc    = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_idx    = csr_ch.index;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign scan_idle  = !issuing_ff && !v1_ff && !v2_ff && !v3_ff;
   assign table_full = (count_ff >= CountW'(MaxN));

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff  <= rrt_nst_pkg::MAX_STEP_RST;
         tolerance_ff <= rrt_nst_pkg::TOLERANCE_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_idx)
            rrt_nst_pkg::CSR_MAX_STEP:  max_step_ff  <= csr_ch.data;
            rrt_nst_pkg::CSR_TOLERANCE: tolerance_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ms2_ff  <= max_step_ff * max_step_ff;
      tol2_ff <= tolerance_ff * tolerance_ff;
   end

   // Node memory: one write port and one registered read port.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      if (state_ff == S_WRITE) begin
         mem_we = 1'b1;
         mem_wa = count_ff[IdxW-1:0];
         mem_wd[RowW-1 -: ParW] = ParW'(nearest_ff);
         for (int k = 0; k < Dim; k++) begin
            mem_wd[k*CoordW +: CoordW] = new_ff[k];
         end
      end else begin
         mem_we = req_acc && ((req_cmd == rrt_nst_pkg::CMD_CLEAR_ROOT) ||
                              (req_cmd == rrt_nst_pkg::CMD_ADD_ROOT && !table_full));
         mem_wa = (req_cmd == rrt_nst_pkg::CMD_CLEAR_ROOT) ? '0 : count_ff[IdxW-1:0];
         mem_wd[RowW-1 -: ParW] = rrt_nst_pkg::ROOT_PARENT;
         for (int k = 0; k < Dim; k++) begin
            mem_wd[k*CoordW +: CoordW] = tgt_in[k];
         end
      end
   end

   always_comb begin
      mem_re = 1'b0;
      mem_ra = rd_idx_ff;
      if ((state_ff == S_SCAN || state_ff == S_CHECK) && issuing_ff) begin
         mem_re = 1'b1;
         mem_ra = scan_addr_ff;
      end else if (state_ff == S_DECIDE) begin
         mem_re = 1'b1;
         mem_ra = nearest_ff;
      end else if (state_ff == S_READ) begin
         mem_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_q_ff <= node_mem[mem_ra];
      end
   end

   // Distance pipeline: squares per joint, then the sum.
   always_comb begin
      logic signed [CoordW:0]   dd;
      logic signed [2*CoordW+1:0] sq_full;
      for (int k = 0; k < Dim; k++) begin
         dd = {rd_q_ff[k*CoordW + CoordW - 1], rd_q_ff[k*CoordW +: CoordW]}
            - {tgt_ff[k][CoordW-1], tgt_ff[k]};
         sq_full = dd * dd;
         sq_in[k] = sq_full[SqW-1:0];
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < Dim; k++) begin
         sum_in = sum_in + D2W'(sq_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Dim; k++) begin
         sq_ff[k] <= sq_in[k];
      end
      sum_ff <= sum_in;
      i1_ff  <= scan_addr_ff;
      i2_ff  <= i1_ff;
      i3_ff  <= i2_ff;
   end

   // Square root and divide steps.
   assign srem_next = {srem_ff[RemW-3:0], rad_ff[D2W-1 -: 2]};
   assign strial    = RemW'({root_ff, 2'b01});
   assign drem_shift = {drem_ff[RootW-1:0], dvd_ff[MagW-1]};
   assign step_diff = {tgt_ff[dim_ff][CoordW-1], tgt_ff[dim_ff]}
                    - {from_ff[dim_ff][CoordW-1], from_ff[dim_ff]};
   assign prod      = step_diff * $signed({1'b0, max_step_ff});
   assign q_signed  = neg_ff ? -$signed({2'b00, dvd_ff[CoordW-1:0]})
                             : $signed({2'b00, dvd_ff[CoordW-1:0]});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_cmd)
                  rrt_nst_pkg::CMD_CLEAR_ROOT: state_in = S_READ;
                  rrt_nst_pkg::CMD_ADD_ROOT:   state_in = table_full ? S_EMIT : S_READ;
                  rrt_nst_pkg::CMD_READ: begin
                     state_in = (CountW'(req_ch.read_index) >= count_ff) ? S_EMIT : S_READ;
                  end
                  rrt_nst_pkg::CMD_GROW: state_in = (count_ff == '0) ? S_EMIT : S_SCAN;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN:   if (scan_idle) state_in = S_DECIDE;
         S_DECIDE: begin
            if (best_ff < D2W'(tol2_ff) || table_full) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_FROM;
            end
         end
         S_FROM:   state_in = (best_ff <= D2W'(ms2_ff)) ? S_WRITE : S_SQRT;
         S_SQRT:   if (sq_cnt_ff == '0) state_in = S_MUL;
         S_MUL:    state_in = S_DIV;
         S_DIV:    if (div_cnt_ff == '0) state_in = S_ACC;
         S_ACC:    state_in = (dim_ff == DimIdxW'(Dim - 1)) ? S_WRITE : S_MUL;
         S_WRITE:  state_in = S_CHECK;
         S_CHECK:  if (v3_ff) state_in = S_EMIT;
         S_READ:   state_in = S_EMIT;
         S_EMIT:   if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         issuing_ff  <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         has_best_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff <= issuing_ff && (state_ff == S_SCAN || state_ff == S_CHECK);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if ((state_ff == S_SCAN || state_ff == S_CHECK) && issuing_ff) begin
            if (scan_addr_ff == scan_last_ff) begin
               issuing_ff <= 1'b0;
            end else begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
            end
         end
         if (state_ff == S_SCAN && v3_ff && (!has_best_ff || sum_ff < best_ff)) begin
            best_ff     <= sum_ff;
            nearest_ff  <= i3_ff;
            has_best_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  for (int k = 0; k < Dim; k++) begin
                     tgt_ff[k] <= tgt_in[k];
                  end
                  status_ff <= rrt_nst_pkg::ST_DONE;
                  unique case (req_cmd)
                     rrt_nst_pkg::CMD_CLEAR_ROOT: begin
                        count_ff  <= CountW'(1);
                        rd_idx_ff <= '0;
                     end
                     rrt_nst_pkg::CMD_ADD_ROOT: begin
                        if (table_full) begin
                           status_ff <= rrt_nst_pkg::ST_FULL;
                        end else begin
                           count_ff  <= count_ff + 1'b1;
                           rd_idx_ff <= count_ff[IdxW-1:0];
                        end
                     end
                     rrt_nst_pkg::CMD_READ: begin
                        rd_idx_ff <= req_ch.read_index;
                        if (CountW'(req_ch.read_index) >= count_ff) begin
                           status_ff <= rrt_nst_pkg::ST_RANGE;
                        end
                     end
                     rrt_nst_pkg::CMD_GROW: begin
                        if (count_ff == '0) begin
                           status_ff <= rrt_nst_pkg::ST_RANGE;
                        end else begin
                           scan_addr_ff <= '0;
                           scan_last_ff <= IdxW'(count_ff - 1'b1);
                           issuing_ff   <= 1'b1;
                           has_best_ff  <= 1'b0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_DECIDE: begin
               rd_idx_ff <= nearest_ff;
               if (best_ff < D2W'(tol2_ff)) begin
                  status_ff <= rrt_nst_pkg::ST_REACHED;
               end else if (table_full) begin
                  status_ff <= rrt_nst_pkg::ST_FULL;
               end
            end
            S_FROM: begin
               for (int k = 0; k < Dim; k++) begin
                  from_ff[k] <= rd_q_ff[k*CoordW +: CoordW];
                  new_ff[k]  <= tgt_ff[k];
               end
               rad_ff    <= best_ff;
               root_ff   <= '0;
               srem_ff   <= '0;
               sq_cnt_ff <= SqCntW'(RootW - 1);
               dim_ff    <= '0;
            end
            S_SQRT: begin
               rad_ff    <= rad_ff << 2;
               sq_cnt_ff <= sq_cnt_ff - 1'b1;
               if (srem_next >= strial) begin
                  srem_ff <= srem_next - strial;
                  root_ff <= {root_ff[RootW-2:0], 1'b1};
               end else begin
                  srem_ff <= srem_next;
                  root_ff <= {root_ff[RootW-2:0], 1'b0};
               end
            end
            S_MUL: begin
               neg_ff     <= prod[ProdW-1];
               dvd_ff     <= prod[ProdW-1] ? MagW'(-prod) : MagW'(prod);
               drem_ff    <= '0;
               div_cnt_ff <= DivCntW'(MagW - 1);
            end
            S_DIV: begin
               div_cnt_ff <= div_cnt_ff - 1'b1;
               if (drem_shift >= {1'b0, root_ff}) begin
                  drem_ff <= drem_shift - {1'b0, root_ff};
                  dvd_ff  <= {dvd_ff[MagW-2:0], 1'b1};
               end else begin
                  drem_ff <= drem_shift;
                  dvd_ff  <= {dvd_ff[MagW-2:0], 1'b0};
               end
            end
            S_ACC: begin
               new_ff[dim_ff] <= CoordW'({{2{from_ff[dim_ff][CoordW-1]}}, from_ff[dim_ff]}
                                         + q_signed);
               dim_ff <= dim_ff + 1'b1;
            end
            S_WRITE: begin
               count_ff     <= count_ff + 1'b1;
               rd_idx_ff    <= count_ff[IdxW-1:0];
               scan_addr_ff <= count_ff[IdxW-1:0];
               scan_last_ff <= count_ff[IdxW-1:0];
               issuing_ff   <= 1'b1;
            end
            S_CHECK: begin
               if (v3_ff) begin
                  status_ff <= (sum_ff < D2W'(tol2_ff)) ? rrt_nst_pkg::ST_REACHED
                                                        : rrt_nst_pkg::ST_ADVANCED;
               end
            end
            default: ;
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_EMIT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EMIT && rsp_free) begin
         rsp_status_ff <= status_ff;
         if (status_ff == rrt_nst_pkg::ST_FULL || status_ff == rrt_nst_pkg::ST_RANGE) begin
            rsp_node_ff   <= '0;
            rsp_parent_ff <= '0;
            for (int k = 0; k < Dim; k++) begin
               rsp_coord_ff[k] <= '0;
            end
         end else begin
            rsp_node_ff   <= rd_idx_ff;
            rsp_parent_ff <= rd_q_ff[RowW-1 -: ParW];
            for (int k = 0; k < Dim; k++) begin
               rsp_coord_ff[k] <= rd_q_ff[k*CoordW +: CoordW];
            end
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.node_index   = rsp_node_ff;
   assign rsp_ch.parent_index = rsp_parent_ff;
   assign rsp_ch.out_coord_0  = rsp_coord_ff[0];
   assign rsp_ch.out_coord_1  = rsp_coord_ff[1];
   assign rsp_ch.out_coord_2  = rsp_coord_ff[2];
   assign rsp_ch.out_coord_3  = rsp_coord_ff[3];
   assign rsp_ch.out_coord_4  = rsp_coord_ff[4];
   assign rsp_ch.out_coord_5  = rsp_coord_ff[5];

   assign rsp_err = rsp_valid_ff && (rsp_status_ff == rrt_nst_pkg::ST_FULL ||
                                     rsp_status_ff == rrt_nst_pkg::ST_RANGE);

   `RRT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CountW'(MaxN))
   `RRT_ASSERT_IMPLY(a_no_write_in_scan, clock, reset, mem_we, state_ff != S_SCAN)
   `RRT_ASSERT_IMPLY(a_divisor_nonzero, clock, reset, state_ff == S_DIV, root_ff != '0)
   `RRT_ASSERT_IMPLY(a_error_zero, clock, reset, rsp_err, rsp_node_ff == '0 && rsp_parent_ff == '0)
endmodule
